@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the evaluator.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IASE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IASE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/iase_pkg.sv @@
// Shared constants and types of the infix add/sub evaluator.
// No dependencies; used by the top level and the checker.
package iase_pkg;

	// Depth of the value stack and of the operator stack.
	localparam int STACK_DEPTH = 64;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Character codes recognized in the expression.
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_OPEN  = 8'h28;
	localparam logic [7:0] CHAR_CLOSE = 8'h29;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Operator stack entries.
	typedef enum logic [1:0] {
		OP_PLUS  = 2'd0,
		OP_MINUS = 2'd1,
		OP_OPEN  = 2'd2
	} op_t;

endpackage

@@ rtl/iase_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the value stack and the operator stack.
module iase_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data appears in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/infix_add_sub_paren_evaluator_top.sv @@
// Top level of the infix add/sub evaluator with parentheses (two-stack scheme).
// Depends on iase_pkg and iase_ram.
//
//  channel | dir | word                           | handshake
//  s_*     | in  | tdata=char_code, tlast=last    | s_tvalid & s_tready
//  m_*     | out | tdata=value, tuser=error       | m_tvalid & m_tready
//
// A digit, space, '(' or other character goes through S_IDLE and S_FLUSH;
// '+', '-' and ')' add S_RCHK, S_REX/S_RCHK per reduction and S_POST;
// the last character adds S_END and its reductions; S_REX awaits stack reads.
// Stacks are tracked by counts, so reset needs no clearing pass.
// The finished result sits in an output register; the block stalls only when
// a new result is ready while the previous one has not been taken.
module infix_add_sub_paren_evaluator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic        m_tuser    // [0] error
);

	localparam int IDX_W = iase_pkg::IDX_W;
	localparam int CNT_W = iase_pkg::CNT_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FLUSH = 7'b0000010,
		S_RCHK  = 7'b0000100,
		S_REX   = 7'b0001000,
		S_POST  = 7'b0010000,
		S_END   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [7:0]       char_q;
	logic             last_q;
	logic [CNT_W-1:0] vcnt_q, vcnt_d;
	logic [CNT_W-1:0] ocnt_q, ocnt_d;
	logic [31:0]      vtop_q, vtop_d;
	iase_pkg::op_t    otop_q, otop_d;
	logic [31:0]      bottom_q, bottom_d;
	logic [31:0]      pend_q, pend_d;
	logic             numact_q, numact_d;
	logic             lwn_q, lwn_d;
	logic             err_q, err_d;
	logic             final_q, final_d;
	logic             out_valid_q;
	logic [31:0]      out_value_q;
	logic             out_err_q;
	logic             out_load;

	// Stack memory ports.
	logic             v_we, o_we;
	logic [IDX_W-1:0] v_waddr, o_waddr, v_raddr, o_raddr;
	logic [31:0]      v_wdata, v_rdata;
	logic [1:0]       o_wdata, o_rdata;
	logic [CNT_W-1:0] vcnt_m2, ocnt_m2;

	// Push requests, resolved after the sequencer case.
	logic             push_v, push_o;
	logic [31:0]      push_val;
	iase_pkg::op_t    push_op;

	// Character classes.
	logic is_digit, is_space, is_plus, is_minus, is_open, is_close;
	logic [7:0]  digit_val;
	logic [31:0] res;

	assign is_digit  = (char_q >= iase_pkg::CHAR_ZERO) && (char_q <= iase_pkg::CHAR_NINE);
	assign is_space  = (char_q == iase_pkg::CHAR_SPACE);
	assign is_plus   = (char_q == iase_pkg::CHAR_PLUS);
	assign is_minus  = (char_q == iase_pkg::CHAR_MINUS);
	assign is_open   = (char_q == iase_pkg::CHAR_OPEN);
	assign is_close  = (char_q == iase_pkg::CHAR_CLOSE);
	assign digit_val = char_q - iase_pkg::CHAR_ZERO;

	assign vcnt_m2 = vcnt_q - CNT_W'(2);
	assign ocnt_m2 = ocnt_q - CNT_W'(2);
	assign v_raddr = vcnt_m2[IDX_W-1:0];
	assign o_raddr = ocnt_m2[IDX_W-1:0];

	// Reduction result: the second entry from the top combined with the top.
	assign res = (otop_q == iase_pkg::OP_MINUS) ? (v_rdata - vtop_q) : (v_rdata + vtop_q);

	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_err_q;

	iase_ram #(.WIDTH(32), .DEPTH(iase_pkg::STACK_DEPTH)) u_vstack (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	iase_ram #(.WIDTH(2), .DEPTH(iase_pkg::STACK_DEPTH)) u_ostack (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	// Sequencer and stack update logic.
	always_comb begin
		state_d  = state_q;
		vcnt_d   = vcnt_q;
		ocnt_d   = ocnt_q;
		vtop_d   = vtop_q;
		otop_d   = otop_q;
		bottom_d = bottom_q;
		pend_d   = pend_q;
		numact_d = numact_q;
		lwn_d    = lwn_q;
		err_d    = err_q;
		final_d  = final_q;
		v_we     = 1'b0;
		v_waddr  = vcnt_q[IDX_W-1:0];
		v_wdata  = 32'd0;
		o_we     = 1'b0;
		o_waddr  = ocnt_q[IDX_W-1:0];
		o_wdata  = 2'd0;
		push_v   = 1'b0;
		push_val = pend_q;
		push_o   = 1'b0;
		push_op  = iase_pkg::OP_PLUS;

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// Any character other than a digit or a space ends the number.
				if (!is_digit && !is_space && numact_q) begin
					push_v   = 1'b1;
					pend_d   = 32'd0;
					numact_d = 1'b0;
					lwn_d    = 1'b1;
				end
				if (is_digit) begin
					pend_d   = (pend_q << 3) + (pend_q << 1) + {24'd0, digit_val};
					numact_d = 1'b1;
				end
				if (is_open) begin
					push_o  = 1'b1;
					push_op = iase_pkg::OP_OPEN;
					lwn_d   = 1'b0;
				end
				if (is_plus || is_minus || is_close) begin
					state_d = S_RCHK;
				end else if (last_q) begin
					state_d = S_END;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RCHK: begin
				// Both stack reads are issued here and used in the next state.
				if (ocnt_q != '0 && otop_q != iase_pkg::OP_OPEN) begin
					state_d = S_REX;
				end else if (final_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_POST;
				end
			end
			S_REX: begin
				ocnt_d = ocnt_q - CNT_W'(1);
				otop_d = iase_pkg::op_t'(o_rdata);
				if (vcnt_q < CNT_W'(2)) begin
					err_d = 1'b1;
				end else begin
					v_we    = 1'b1;
					v_waddr = vcnt_m2[IDX_W-1:0];
					v_wdata = res;
					vtop_d  = res;
					vcnt_d  = vcnt_q - CNT_W'(1);
					if (vcnt_q == CNT_W'(2)) begin
						bottom_d = res;
					end
				end
				state_d = S_RCHK;
			end
			S_POST: begin
				if (is_close) begin
					// Drop the matching open parenthesis.
					if (ocnt_q != '0) begin
						ocnt_d = ocnt_q - CNT_W'(1);
						otop_d = iase_pkg::op_t'(o_rdata);
					end else begin
						err_d = 1'b1;
					end
				end else begin
					// A minus that does not follow a number is unary.
					if (is_minus && !lwn_q) begin
						push_v   = 1'b1;
						push_val = 32'd0;
					end
					push_o  = 1'b1;
					push_op = is_minus ? iase_pkg::OP_MINUS : iase_pkg::OP_PLUS;
					lwn_d   = 1'b0;
				end
				state_d = last_q ? S_END : S_IDLE;
			end
			S_END: begin
				if (numact_q) begin
					push_v   = 1'b1;
					pend_d   = 32'd0;
					numact_d = 1'b0;
					lwn_d    = 1'b1;
				end
				final_d = 1'b1;
				state_d = S_RCHK;
			end
			S_OUT: begin
				if (out_load) begin
					vcnt_d   = '0;
					ocnt_d   = '0;
					pend_d   = 32'd0;
					numact_d = 1'b0;
					lwn_d    = 1'b0;
					err_d    = 1'b0;
					final_d  = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Value push: dropped with an error when the stack is full.
		if (push_v) begin
			if (vcnt_q >= CNT_W'(iase_pkg::STACK_DEPTH)) begin
				err_d = 1'b1;
			end else begin
				v_we    = 1'b1;
				v_waddr = vcnt_q[IDX_W-1:0];
				v_wdata = push_val;
				vtop_d  = push_val;
				vcnt_d  = vcnt_q + CNT_W'(1);
				if (vcnt_q == '0) begin
					bottom_d = push_val;
				end
			end
		end

		// Operator push: dropped with an error when the stack is full.
		if (push_o) begin
			if (ocnt_q >= CNT_W'(iase_pkg::STACK_DEPTH)) begin
				err_d = 1'b1;
			end else begin
				o_we    = 1'b1;
				o_waddr = ocnt_q[IDX_W-1:0];
				o_wdata = push_op;
				otop_d  = push_op;
				ocnt_d  = ocnt_q + CNT_W'(1);
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcnt_q      <= '0;
			ocnt_q      <= '0;
			pend_q      <= 32'd0;
			numact_q    <= 1'b0;
			lwn_q       <= 1'b0;
			err_q       <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			vcnt_q   <= vcnt_d;
			ocnt_q   <= ocnt_d;
			pend_q   <= pend_d;
			numact_q <= numact_d;
			lwn_q    <= lwn_d;
			err_q    <= err_d;
			final_q  <= final_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: input word, cached stack tops, the bottom value and the output word.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_q <= s_tdata;
			last_q <= s_tlast;
		end
		vtop_q   <= vtop_d;
		otop_q   <= otop_d;
		bottom_q <= bottom_d;
		if (out_load) begin
			out_value_q <= (vcnt_q != '0) ? bottom_q : 32'd0;
			out_err_q   <= err_q || (vcnt_q == '0);
		end
	end

endmodule

@@ rtl/iase_checker.sv @@
// Port-level checker for the infix add/sub evaluator, bound to the top level.
// Depends on iase_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iase_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	logic s_acc;
	logic quick_char;

	assign s_acc      = s_tvalid && s_tready;
	assign quick_char = ((s_tdata >= iase_pkg::CHAR_ZERO) && (s_tdata <= iase_pkg::CHAR_NINE))
		|| (s_tdata == iase_pkg::CHAR_SPACE);

	// A stalled result word stays offered and unchanged.
	`IASE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
	`IASE_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// One character is worked on at a time.
	`IASE_ASSERT_NXT(a_one_at_a_time, s_acc, !s_tready, "new word taken while busy")

	// A digit or space that does not end the expression returns to ready via S_FLUSH.
	`IASE_ASSERT_NXT(a_quick_char, s_acc && !s_tlast && quick_char, ##1 s_tready, "digit or space took too long")

endmodule

bind infix_add_sub_paren_evaluator_top iase_checker u_iase_checker (.*);
